FILE: src/cocl_pkg.sv
// Shared types and constants for the column occlusion range clipper.
// Used by cocl_ctrl, cocl_dpath and column_occlusion_range_clipper; no dependencies.
`default_nettype none

package cocl_pkg;

   localparam int COL_W = 10;
   localparam int VW_W = 11;
   localparam logic [VW_W-1:0] VIEW_WIDTH_RESET = 11'd320;
   localparam int MAX_RESULTS = 32;
   localparam int FRAG_CNT_W = $clog2(MAX_RESULTS + 1);

   // Operation codes
   localparam logic [1:0] OP_CLEAR    = 2'd0;
   localparam logic [1:0] OP_SOLID    = 2'd1;
   localparam logic [1:0] OP_PASS     = 2'd2;
   localparam logic [1:0] OP_RESERVED = 2'd3;

   typedef struct packed {
      logic [1:0]       operation;
      logic [COL_W-1:0] first_column;
      logic [COL_W-1:0] last_column;
   } req_type;

   typedef struct packed {
      logic [COL_W-1:0] fragment_first;
      logic [COL_W-1:0] fragment_last;
      logic             last_fragment;
      logic             list_full;
   } rsp_type;

   // Datapath commands
   typedef enum logic [3:0] {
      DP_IDLE,
      DP_INIT_LEFT,
      DP_INIT_RIGHT_RST,
      DP_INIT_RIGHT_CFG,
      DP_LOAD,
      DP_SCAN,
      DP_WALK,
      DP_MERGE,
      DP_COMPACT,
      DP_SHIFT,
      DP_INSERT,
      DP_FINISH
   } dp_cmd_type;

   // Datapath status
   typedef struct packed {
      logic req_ok;
      logic scan_more;
      logic ahead;
      logic disjoint;
      logic covered;
      logic walk_more;
      logic walk_cover;
      logic solid;
      logic full;
      logic nx_eq_s;
      logic compact_more;
      logic shift_more;
   } dp_status_type;

endpackage

`default_nettype wire

FILE: src/column_occlusion_range_clipper.sv
// Top level of the column occlusion range clipper: controller plus datapath.
// Depends on cocl_pkg, cocl_ctrl and cocl_dpath.
`default_nettype none

// A request is taken when start is high and busy is low. A clip request
// keeps busy high while it scans, walks over or moves entries: the list
// lives in a single memory with one write and one registered read port,
// so the scan, the walk over bridged gaps, the compaction after a merge
// and the upward shift for an insert each move one entry per cycle. A
// clear request keeps busy high while it rewrites the two sentinel
// entries, and after reset the block is busy while it writes them.
// Fragments leave on rsp_data, one per cycle with rsp_strobe high, and
// cannot be held off; the final fragment of a request carries
// last_fragment and comes out in the same cycle that busy drops.
// Ignored requests produce no fragments.
module column_occlusion_range_clipper #(
   parameter int MAX_RANGES = 32,
   parameter int MAX_COLUMNS = 1024
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire cocl_pkg::req_type         req_data,
   output logic                           rsp_strobe,
   output cocl_pkg::rsp_type              rsp_data,
   input  wire logic                      csr_we,
   input  wire logic [cocl_pkg::VW_W-1:0] csr_wdata
);

   cocl_pkg::dp_cmd_type    cmd;
   cocl_pkg::dp_status_type status;

   cocl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .operation (req_data.operation),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy)
   );

   cocl_dpath #(
      .MAX_RANGES  (MAX_RANGES),
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_data   (req_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // Fragments only come out of work started by a request
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("fragment without preceding busy cycle");

   // Sentinel init must run after reset
   a_init_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> busy)
      else $error("block idle right after reset");

   // Insert only runs while the list has room for one more entry
   a_no_insert_when_full: assert property (@(posedge clock) disable iff (reset)
      (cmd == cocl_pkg::DP_INSERT) |-> !status.full)
      else $error("insert into full list");

endmodule

`default_nettype wire

FILE: src/cocl_dpath.sv
// Datapath: range list memory, scan pointers, fragment staging and result register.
// Depends on cocl_pkg; driven by commands from cocl_ctrl.
`default_nettype none

module cocl_dpath #(
   parameter int MAX_RANGES = 32,
   parameter int MAX_COLUMNS = 1024
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire cocl_pkg::dp_cmd_type      cmd,
   input  wire cocl_pkg::req_type         req_data,
   input  wire logic                      csr_we,
   input  wire logic [cocl_pkg::VW_W-1:0] csr_wdata,
   output cocl_pkg::dp_status_type        status,
   output logic                           rsp_strobe,
   output cocl_pkg::rsp_type              rsp_data
);

   localparam int MAXV = (MAX_COLUMNS > 2047) ? MAX_COLUMNS : 2047;
   localparam int EW = $clog2(MAXV + 2) + 1;
   localparam int AW = $clog2(MAX_RANGES);
   localparam int CW = $clog2(MAX_RANGES + 1);
   localparam logic signed [EW-1:0] ONE = EW'(1);
   localparam logic signed [EW-1:0] NEG_ONE = -ONE;
   localparam logic signed [EW-1:0] RIGHT_END = EW'(MAX_COLUMNS);

   logic [2*EW-1:0] mem [MAX_RANGES];

   logic [cocl_pkg::VW_W-1:0] view_width_ff;
   logic signed [EW-1:0] first_ff, first_in, last_ff, last_in;
   logic signed [EW-1:0] cur_start_ff, cur_start_in, new_end_ff, new_end_in;
   logic signed [EW-1:0] prev_end_ff, prev_end_in;
   logic solid_ff, solid_in;
   logic [CW-1:0] s_ff, s_in, nx_ff, nx_in, cnt_ff, cnt_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in, ptr_ff, ptr_in, wr_addr_ff, wr_addr_in;
   logic have_ff, have_in;
   logic [2*EW-1:0] rd_q_ff;
   logic [CW-1:0] rd_addr;
   logic mem_we;
   logic [CW-1:0] mem_wa;
   logic [2*EW-1:0] mem_wd;

   logic [cocl_pkg::FRAG_CNT_W-1:0] frag_cnt_ff, frag_cnt_in;
   cocl_pkg::rsp_type pend_ff, pend_in, rsp_ff, rsp_in;
   logic pend_valid_ff, pend_valid_in, rsp_valid_ff, rsp_valid_in;

   logic emit_en, emit_full;
   logic signed [EW-1:0] emit_first, emit_last;

   logic signed [EW-1:0] q_start, q_end, req_first, req_last, vw_ext;
   logic rd_on;

   assign q_start = signed'(rd_q_ff[2*EW-1:EW]);
   assign q_end = signed'(rd_q_ff[EW-1:0]);
   assign req_first = signed'({{(EW-cocl_pkg::COL_W){1'b0}}, req_data.first_column});
   assign req_last = signed'({{(EW-cocl_pkg::COL_W){1'b0}}, req_data.last_column});
   assign vw_ext = signed'({{(EW-cocl_pkg::VW_W){1'b0}}, view_width_ff});
   assign rd_on = (ptr_ff >= s_ff);

   // Status flags for the controller
   always_comb begin
      status.req_ok = (req_data.first_column <= req_data.last_column)
         && ({1'b0, req_data.last_column} < view_width_ff);
      status.scan_more = ((s_ff + CW'(1)) < cnt_ff) && (q_end < first_ff - ONE);
      status.ahead = first_ff < q_start;
      status.disjoint = last_ff < q_start - ONE;
      status.covered = last_ff <= q_end;
      status.walk_more = ((nx_ff + CW'(1)) < cnt_ff) && (last_ff >= q_start - ONE);
      status.walk_cover = last_ff <= q_end;
      status.solid = solid_ff;
      status.full = cnt_ff >= CW'(MAX_RANGES);
      status.nx_eq_s = nx_ff == s_ff;
      status.compact_more = i_ff < cnt_ff;
      status.shift_more = rd_on || have_ff;
   end

   // Command decode: next register values, memory port and fragment emission
   always_comb begin
      first_in = first_ff;
      last_in = last_ff;
      solid_in = solid_ff;
      cur_start_in = cur_start_ff;
      new_end_in = new_end_ff;
      prev_end_in = prev_end_ff;
      s_in = s_ff;
      nx_in = nx_ff;
      cnt_in = cnt_ff;
      i_in = i_ff;
      j_in = j_ff;
      ptr_in = ptr_ff;
      wr_addr_in = wr_addr_ff;
      have_in = have_ff;
      rd_addr = '0;
      mem_we = 1'b0;
      mem_wa = '0;
      mem_wd = '0;
      emit_en = 1'b0;
      emit_full = 1'b0;
      emit_first = first_ff;
      emit_last = last_ff;
      unique case (cmd)
         cocl_pkg::DP_IDLE: begin
         end
         cocl_pkg::DP_INIT_LEFT: begin
            mem_we = 1'b1;
            mem_wa = CW'(0);
            mem_wd = {NEG_ONE, NEG_ONE};
         end
         cocl_pkg::DP_INIT_RIGHT_RST: begin
            mem_we = 1'b1;
            mem_wa = CW'(1);
            mem_wd = {signed'({{(EW-cocl_pkg::VW_W){1'b0}}, cocl_pkg::VIEW_WIDTH_RESET}),
                      RIGHT_END};
            cnt_in = CW'(2);
         end
         cocl_pkg::DP_INIT_RIGHT_CFG: begin
            mem_we = 1'b1;
            mem_wa = CW'(1);
            mem_wd = {vw_ext, RIGHT_END};
            cnt_in = CW'(2);
         end
         cocl_pkg::DP_LOAD: begin
            first_in = req_first;
            last_in = req_last;
            solid_in = req_data.operation == cocl_pkg::OP_SOLID;
            s_in = '0;
            rd_addr = '0;
         end
         cocl_pkg::DP_SCAN: begin
            // prefetch the next entry while testing this one
            rd_addr = s_ff + CW'(1);
            ptr_in = cnt_ff - CW'(1);
            have_in = 1'b0;
            if (status.scan_more) begin
               s_in = s_ff + CW'(1);
            end else begin
               nx_in = s_ff;
               prev_end_in = q_end;
               new_end_in = q_end;
               cur_start_in = (status.ahead && solid_ff) ? first_ff : q_start;
               if (status.ahead) begin
                  emit_en = 1'b1;
                  emit_first = first_ff;
                  emit_last = status.disjoint ? last_ff : q_start - ONE;
                  emit_full = status.disjoint && solid_ff && status.full;
               end
            end
         end
         cocl_pkg::DP_WALK: begin
            rd_addr = nx_ff + CW'(2);
            emit_en = 1'b1;
            emit_first = prev_end_ff + ONE;
            if (status.walk_more) begin
               emit_last = q_start - ONE;
               nx_in = nx_ff + CW'(1);
               prev_end_in = q_end;
               new_end_in = q_end;
            end else begin
               emit_last = last_ff;
               new_end_in = last_ff;
            end
         end
         cocl_pkg::DP_MERGE: begin
            mem_we = 1'b1;
            mem_wa = s_ff;
            mem_wd = {cur_start_ff, new_end_ff};
            rd_addr = nx_ff + CW'(1);
            i_in = nx_ff + CW'(1);
            j_in = s_ff + CW'(1);
         end
         cocl_pkg::DP_COMPACT: begin
            // pull surviving entries down over the bridged ones
            if (status.compact_more) begin
               mem_we = 1'b1;
               mem_wa = j_ff;
               mem_wd = rd_q_ff;
               j_in = j_ff + CW'(1);
               i_in = i_ff + CW'(1);
               rd_addr = i_ff + CW'(1);
            end else begin
               cnt_in = j_ff;
            end
         end
         cocl_pkg::DP_SHIFT: begin
            // read one entry, write it one place up on the next cycle
            if (have_ff) begin
               mem_we = 1'b1;
               mem_wa = wr_addr_ff;
               mem_wd = rd_q_ff;
            end
            if (rd_on) begin
               rd_addr = ptr_ff;
               wr_addr_in = ptr_ff + CW'(1);
               ptr_in = ptr_ff - CW'(1);
               have_in = 1'b1;
            end else begin
               have_in = 1'b0;
            end
         end
         cocl_pkg::DP_INSERT: begin
            mem_we = 1'b1;
            mem_wa = s_ff;
            mem_wd = {first_ff, last_ff};
            cnt_in = cnt_ff + CW'(1);
         end
         cocl_pkg::DP_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   // Stage fragments one deep so the final one can carry last_fragment
   always_comb begin
      frag_cnt_in = frag_cnt_ff;
      pend_in = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = 1'b0;
      if (cmd == cocl_pkg::DP_LOAD) begin
         frag_cnt_in = '0;
      end
      if (emit_en && (frag_cnt_ff < cocl_pkg::FRAG_CNT_W'(cocl_pkg::MAX_RESULTS))) begin
         if (pend_valid_ff) begin
            rsp_in = pend_ff;
            rsp_valid_in = 1'b1;
         end
         pend_in.fragment_first = emit_first[cocl_pkg::COL_W-1:0];
         pend_in.fragment_last = emit_last[cocl_pkg::COL_W-1:0];
         pend_in.last_fragment = 1'b0;
         pend_in.list_full = emit_full;
         pend_valid_in = 1'b1;
         frag_cnt_in = frag_cnt_ff + cocl_pkg::FRAG_CNT_W'(1);
      end
      if (cmd == cocl_pkg::DP_FINISH && pend_valid_ff) begin
         rsp_in = pend_ff;
         rsp_in.last_fragment = 1'b1;
         rsp_valid_in = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   // Range memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa[AW-1:0]] <= mem_wd;
      end
      rd_q_ff <= mem[rd_addr[AW-1:0]];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         view_width_ff <= cocl_pkg::VIEW_WIDTH_RESET;
         cnt_ff <= CW'(2);
         have_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         frag_cnt_ff <= '0;
      end else begin
         if (csr_we) begin
            view_width_ff <= csr_wdata;
         end
         cnt_ff <= cnt_in;
         have_ff <= have_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         frag_cnt_ff <= frag_cnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      first_ff <= first_in;
      last_ff <= last_in;
      solid_ff <= solid_in;
      cur_start_ff <= cur_start_in;
      new_end_ff <= new_end_in;
      prev_end_ff <= prev_end_in;
      s_ff <= s_in;
      nx_ff <= nx_in;
      i_ff <= i_in;
      j_ff <= j_in;
      ptr_ff <= ptr_in;
      wr_addr_ff <= wr_addr_in;
      pend_ff <= pend_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

FILE: src/cocl_ctrl.sv
// Controller state machine: sequences list init and clear, scan, walk, merge, compact, shift and insert.
// Depends on cocl_pkg; drives cocl_dpath through commands and reads its status.
`default_nettype none

module cocl_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [1:0]              operation,
   input  wire cocl_pkg::dp_status_type status,
   output cocl_pkg::dp_cmd_type         cmd,
   output logic                         busy
);

   typedef enum logic [3:0] {
      ST_INIT_L,
      ST_INIT_R,
      ST_IDLE,
      ST_CLR_L,
      ST_CLR_R,
      ST_SCAN,
      ST_WALK,
      ST_MERGE,
      ST_COMPACT,
      ST_SHIFT,
      ST_INSERT,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic busy_ff, busy_in;
   logic clip_op;

   assign clip_op = (operation == cocl_pkg::OP_SOLID) || (operation == cocl_pkg::OP_PASS);

   // Next state and command
   always_comb begin
      state_in = state_ff;
      cmd = cocl_pkg::DP_IDLE;
      unique case (state_ff)
         ST_INIT_L: begin
            cmd = cocl_pkg::DP_INIT_LEFT;
            state_in = ST_INIT_R;
         end
         ST_INIT_R: begin
            cmd = cocl_pkg::DP_INIT_RIGHT_RST;
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               if (operation == cocl_pkg::OP_CLEAR) begin
                  state_in = ST_CLR_L;
               end else if (clip_op && status.req_ok) begin
                  cmd = cocl_pkg::DP_LOAD;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_CLR_L: begin
            cmd = cocl_pkg::DP_INIT_LEFT;
            state_in = ST_CLR_R;
         end
         ST_CLR_R: begin
            cmd = cocl_pkg::DP_INIT_RIGHT_CFG;
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            cmd = cocl_pkg::DP_SCAN;
            if (!status.scan_more) begin
               if (status.ahead && status.disjoint) begin
                  state_in = (!status.solid || status.full) ? ST_FINISH : ST_SHIFT;
               end else if (status.covered) begin
                  state_in = status.solid ? ST_MERGE : ST_FINISH;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            cmd = cocl_pkg::DP_WALK;
            if (!status.walk_more || status.walk_cover) begin
               state_in = status.solid ? ST_MERGE : ST_FINISH;
            end
         end
         ST_MERGE: begin
            cmd = cocl_pkg::DP_MERGE;
            state_in = status.nx_eq_s ? ST_FINISH : ST_COMPACT;
         end
         ST_COMPACT: begin
            cmd = cocl_pkg::DP_COMPACT;
            if (!status.compact_more) begin
               state_in = ST_FINISH;
            end
         end
         ST_SHIFT: begin
            cmd = cocl_pkg::DP_SHIFT;
            if (!status.shift_more) begin
               state_in = ST_INSERT;
            end
         end
         ST_INSERT: begin
            cmd = cocl_pkg::DP_INSERT;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd = cocl_pkg::DP_FINISH;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      busy_in = state_in != ST_IDLE;
   end

   // Hold state and busy
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT_L;
         busy_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         busy_ff <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule

`default_nettype wire
